### rtl/pdtq_pkg.sv
// ----------------------------------------------------------------------------
// pdtq_pkg: shared types and constants of the periodic delta timer queue
// Timer cell contents, chain operation codes and command codes.
// ----------------------------------------------------------------------------
package pdtq_pkg;

  // default number of timer cells
  localparam int ENTRIES_DEF = 32;
  // expiries reported by one tick at most
  localparam int MAX_RESULTS = 32;
  localparam int RES_IW      = $clog2(MAX_RESULTS);
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

  // command codes of the input transaction
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_REG     = 2'd1,
    ACT_UNREG   = 2'd2,
    ACT_UNREG_H = 2'd3
  } action_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_REMOVE = 2'd1,
    CH_INSERT = 2'd2,
    CH_FIRE   = 2'd3
  } chain_op_t;

  // one timer; rem is the absolute remaining time of this timer
  typedef struct packed {
    logic        valid;
    logic [15:0] handler;
    logic [15:0] event_id;
    logic [31:0] period;
    logic [31:0] rem;
  } entry_t;

  // control broadcast from the sequencer to the chain
  typedef struct packed {
    chain_op_t   op;
    logic        del_en;
    logic        hnd_only;
    logic [15:0] key_h;
    logic [15:0] key_e;
    logic [32:0] age;
  } chain_ctl_t;

endpackage

### rtl/pdtq_cell.sv
// ----------------------------------------------------------------------------
// pdtq_cell: one timer cell of the sorted chain
// Holds one timer and shifts left or right, ages, or takes a new timer.
// ----------------------------------------------------------------------------
module pdtq_cell
  import pdtq_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  entry_t     new_e,
  input  entry_t     left_e,
  input  entry_t     right_e,
  input  logic       left_lt,
  input  logic       right_lt,
  input  logic       hit_in,
  output entry_t     cur,
  output logic       lt,
  output logic       hit_out
);

  entry_t cur_r, cur_nxt, src;
  logic   match;

  assign cur = cur_r;

  // ordering and key compare
  always_comb begin
    lt      = cur_r.valid && (cur_r.rem < new_e.period);
    match   = cur_r.valid && (cur_r.handler == ctl.key_h) &&
              (ctl.hnd_only || (cur_r.event_id == ctl.key_e));
    hit_out = hit_in | match;
  end

  // next contents
  always_comb begin
    src     = cur_r;
    cur_nxt = cur_r;
    unique case (ctl.op)
      CH_HOLD: begin
        cur_nxt = cur_r;
      end
      CH_REMOVE: begin
        src     = (ctl.del_en && hit_out) ? right_e : cur_r;
        cur_nxt = src;
        cur_nxt.rem = ({1'b0, src.rem} <= ctl.age) ? 32'd0 : (src.rem - ctl.age[31:0]);
      end
      CH_INSERT: begin
        if (lt) begin
          cur_nxt = cur_r;
        end else if (left_lt) begin
          cur_nxt = new_e;
        end else begin
          cur_nxt = left_e;
        end
      end
      CH_FIRE: begin
        if (right_lt) begin
          cur_nxt = right_e;
        end else if (FIRST || lt) begin
          cur_nxt = new_e;
        end else begin
          cur_nxt = cur_r;
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

endmodule

### rtl/periodic_delta_timer_queue.sv
// ----------------------------------------------------------------------------
// periodic_delta_timer_queue: periodic timer manager on a sorted cell chain
// Timers kept earliest first; tick, register and unregister commands.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Unregister one key passes S_CMD and
// S_STAT to its status result, an accepted register also S_INS; unregister
// all of a handler repeats S_CMD while a timer of it is found. A tick passes
// S_CMD, stays in S_FIRE while the head is due, then passes S_DRD and S_DLD
// per expiry result, each held in S_WAIT until taken; a tick that expires
// nothing gives no result. All cells age and shift in S_CMD, insert in S_INS;
// expiries go one per cycle, while there is room, to a small result memory.
module periodic_delta_timer_queue
  import pdtq_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_handler_id,
  input  logic [15:0] in_event_id,
  input  logic [31:0] in_period_us,
  input  logic [47:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic        out_status,
  output logic [15:0] out_fired_handler,
  output logic [15:0] out_fired_event,
  output logic        out_last,
  output logic        out_queue_empty,
  output logic [31:0] out_next_due_us
);

  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CMD  = 8'b0000_0010,
    S_INS  = 8'b0000_0100,
    S_FIRE = 8'b0000_1000,
    S_STAT = 8'b0001_0000,
    S_DRD  = 8'b0010_0000,
    S_DLD  = 8'b0100_0000,
    S_WAIT = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  action_t         act_r;
  logic [15:0]     h_r, e_r;
  logic [31:0]     per_r;
  logic [47:0]     now_r, stamp_r;
  logic [32:0]     age_r;
  logic [CW-1:0]   count_r;
  logic            st_r;
  logic [RES_CW-1:0] n_r;
  logic [RES_IW-1:0] rd_r;
  logic [31:0]     rd_data_r;
  logic [31:0]     fifo_mem [MAX_RESULTS];

  logic        out_valid_r, out_kind_r, out_status_r, out_last_r, out_empty_r;
  logic [15:0] out_h_r, out_e_r;
  logic [31:0] out_due_r;

  chain_ctl_t ctl;
  entry_t     new_e;
  entry_t     cells [ENTRIES];
  logic       lts   [ENTRIES];
  logic       hits  [ENTRIES];

  logic        found, reg_ok, fire_go, in_acc, out_acc;
  logic [47:0] diff;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign found    = hits[ENTRIES-1];
  assign reg_ok   = (h_r != 16'd0) && (per_r != 32'd0) &&
                    (found || (count_r != CW'(ENTRIES)));
  assign fire_go  = cells[0].valid && (cells[0].rem == 32'd0) &&
                    (n_r != RES_CW'(MAX_RESULTS));
  assign diff     = in_now_us - stamp_r;

  // cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t le, re;
    logic   llt, rlt, hin;
    if (i == 0) begin : g_head
      assign le  = '0;
      assign llt = 1'b1;
      assign hin = 1'b0;
    end else begin : g_body
      assign le  = cells[i-1];
      assign llt = lts[i-1];
      assign hin = hits[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign re  = '0;
      assign rlt = 1'b0;
    end else begin : g_mid
      assign re  = cells[i+1];
      assign rlt = lts[i+1];
    end
    pdtq_cell #(.FIRST(i == 0)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .new_e   (new_e),
      .left_e  (le),
      .right_e (re),
      .left_lt (llt),
      .right_lt(rlt),
      .hit_in  (hin),
      .cur     (cells[i]),
      .lt      (lts[i]),
      .hit_out (hits[i])
    );
  end

  // chain control
  always_comb begin
    ctl          = '0;
    ctl.op       = CH_HOLD;
    ctl.key_h    = h_r;
    ctl.key_e    = e_r;
    ctl.hnd_only = (act_r == ACT_UNREG_H);
    new_e        = '{valid: 1'b1, handler: h_r, event_id: e_r, period: per_r, rem: per_r};
    unique case (state_r)
      S_CMD: begin
        ctl.op = CH_REMOVE;
        unique case (act_r)
          ACT_TICK:    ctl.age = age_r;
          ACT_REG: begin
            ctl.age    = reg_ok ? age_r : 33'd0;
            ctl.del_en = reg_ok && found;
          end
          ACT_UNREG:   ctl.del_en = 1'b1;
          ACT_UNREG_H: ctl.del_en = 1'b1;
          default:     ctl.age = 33'd0;
        endcase
      end
      S_INS: begin
        ctl.op = CH_INSERT;
      end
      S_FIRE: begin
        ctl.op = fire_go ? CH_FIRE : CH_HOLD;
        new_e  = '{valid: 1'b1, handler: cells[0].handler, event_id: cells[0].event_id,
                   period: cells[0].period, rem: cells[0].period};
      end
      default: begin
        ctl.op = CH_HOLD;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_CMD;
      S_CMD: begin
        unique case (act_r)
          ACT_TICK:    state_nxt = S_FIRE;
          ACT_REG:     state_nxt = reg_ok ? S_INS : S_STAT;
          ACT_UNREG:   state_nxt = S_STAT;
          ACT_UNREG_H: state_nxt = found ? S_CMD : S_STAT;
          default:     state_nxt = S_STAT;
        endcase
      end
      S_INS:  state_nxt = S_STAT;
      S_FIRE: begin
        if (!fire_go) begin
          state_nxt = (n_r == '0) ? S_IDLE : S_DRD;
        end
      end
      S_STAT: state_nxt = S_WAIT;
      S_DRD:  state_nxt = S_DLD;
      S_DLD:  state_nxt = S_WAIT;
      S_WAIT: if (out_acc) state_nxt = out_last_r ? S_IDLE : S_DRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stamp_r     <= '0;
      count_r     <= '0;
      n_r         <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CMD) begin
        if ((act_r == ACT_TICK) || ((act_r == ACT_REG) && reg_ok)) begin
          stamp_r <= now_r;
        end
        if ((act_r != ACT_TICK) && found && ((act_r != ACT_REG) || reg_ok)) begin
          count_r <= count_r - CW'(1);
        end
      end
      if (state_r == S_INS) count_r <= count_r + CW'(1);
      if (in_acc) begin
        n_r  <= '0;
        rd_r <= '0;
      end
      if ((state_r == S_FIRE) && fire_go) n_r <= n_r + RES_CW'(1);
      if ((state_r == S_WAIT) && out_acc && !out_last_r) rd_r <= rd_r + RES_IW'(1);
      if ((state_r == S_STAT) || (state_r == S_DLD)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= action_t'(in_action);
      h_r   <= in_handler_id;
      e_r   <= in_event_id;
      per_r <= in_period_us;
      now_r <= in_now_us;
      if (in_now_us < stamp_r) begin
        age_r <= 33'd0;
      end else if (diff[47:32] != 16'd0) begin
        age_r <= {1'b1, 32'd0};
      end else begin
        age_r <= {1'b0, diff[31:0]};
      end
    end
    if (state_r == S_CMD) begin
      unique case (act_r)
        ACT_REG:   st_r <= !reg_ok;
        ACT_UNREG: st_r <= !found;
        default:   st_r <= 1'b0;
      endcase
    end
    if ((state_r == S_STAT) || (state_r == S_DLD)) begin
      out_kind_r   <= (state_r == S_DLD);
      out_status_r <= (state_r == S_STAT) ? st_r : 1'b0;
      out_h_r      <= (state_r == S_DLD) ? rd_data_r[31:16] : 16'd0;
      out_e_r      <= (state_r == S_DLD) ? rd_data_r[15:0] : 16'd0;
      out_last_r   <= (state_r == S_STAT) || (RES_CW'(rd_r) + RES_CW'(1) == n_r);
      out_empty_r  <= (count_r == '0);
      out_due_r    <= cells[0].valid ? cells[0].rem : 32'd0;
    end
  end

  // expiry result memory
  always_ff @(posedge clk) begin
    if ((state_r == S_FIRE) && fire_go) begin
      fifo_mem[n_r[RES_IW-1:0]] <= {cells[0].handler, cells[0].event_id};
    end
    if (state_r == S_DRD) begin
      rd_data_r <= fifo_mem[rd_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = out_status_r;
  assign out_fired_handler = out_h_r;
  assign out_fired_event   = out_e_r;
  assign out_last          = out_last_r;
  assign out_queue_empty   = out_empty_r;
  assign out_next_due_us   = out_due_r;

`ifndef NO_ASSERTIONS
  // no new transaction while a result is pending
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r) else $error("input taken with result pending");
  // armed count within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES)) else $error("armed count overflow");
  // head cell occupancy follows the armed count
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cells[0].valid == (count_r != '0)) else $error("head valid mismatch");
  // status results carry no timer identity
  a_status_ids: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |-> (out_h_r == 16'd0 && out_e_r == 16'd0))
    else $error("status result with timer id");
`endif

endmodule
